[hdl/cbpe_pkg.sv]
`timescale 1ns / 1ps
// shared constants and register codes for the cubic bezier point evaluator
// no dependencies

package cbpe_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_CTRL       = 4;
    localparam int CFG_IDX_W      = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X0 = 3'd0,
        REG_Y0 = 3'd1,
        REG_X1 = 3'd2,
        REG_Y1 = 3'd3,
        REG_X2 = 3'd4,
        REG_Y2 = 3'd5,
        REG_X3 = 3'd6,
        REG_Y3 = 3'd7
    } cfg_reg_t;

endpackage

[hdl/cubic_bezier_point_eval_unit.sv]
`timescale 1ns / 1ps
// 5 register stages: s1, s2, s3, s4 and the output register, passed in order by each word
// throughput: one word per cycle unless stalled; the three 17x17 products, the four 33x17
// weights and the eight coordinate products each have their own stage, so no stage is shared
// stalls ripple back stage by stage; a bubble in the pipe still takes a new word
// reset (async, active low) clears all valid bits and the control point registers
// depends on cbpe_pkg

module cubic_bezier_point_eval_unit #(
    parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = cbpe_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [cbpe_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [COORD_BITS-1:0]                cfg_data,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((FRAC_BITS+8)/8)*8-1:0]       s_tdata,   // u_param
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata    // point_x, point_y
);

    import cbpe_pkg::*;

    localparam int UW    = FRAC_BITS + 1;             // u and 1-u
    localparam int SQ_W  = 2 * FRAC_BITS + 1;         // second degree products
    localparam int CU_W  = 3 * FRAC_BITS + 1;         // bernstein weights without binomial
    localparam int CP_W  = COORD_BITS + 2;            // coordinate times binomial
    localparam int SUM_W = CP_W + 2;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    localparam logic [UW-1:0] ONE_FIX = UW'(1) << FRAC_BITS;

    // control points, middle two pre-scaled by three
    logic [CP_W-1:0] cx_reg [NUM_CTRL];
    logic [CP_W-1:0] cy_reg [NUM_CTRL];
    logic [CP_W-1:0] cfg_ext;
    logic [CP_W-1:0] cfg_x3;

    assign cfg_ext = CP_W'(cfg_data);
    assign cfg_x3  = cfg_ext + (cfg_ext << 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CTRL; i++)
            begin
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_X0:  cx_reg[0] <= cfg_ext;
                REG_Y0:  cy_reg[0] <= cfg_ext;
                REG_X1:  cx_reg[1] <= cfg_x3;
                REG_Y1:  cy_reg[1] <= cfg_x3;
                REG_X2:  cx_reg[2] <= cfg_x3;
                REG_Y2:  cy_reg[2] <= cfg_x3;
                REG_X3:  cx_reg[3] <= cfg_ext;
                REG_Y3:  cy_reg[3] <= cfg_ext;
                default: ;
            endcase
        end
    end

    // stage enables, a stage moves when empty or when the next one moves
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, out_vld_reg;
    logic s1_en, s2_en, s3_en, s4_en, out_en;

    assign out_en   = !out_vld_reg || m_tready;
    assign s4_en    = !s4_vld_reg || out_en;
    assign s3_en    = !s3_vld_reg || s4_en;
    assign s2_en    = !s2_vld_reg || s3_en;
    assign s1_en    = !s1_vld_reg || s2_en;
    assign s_tready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_vld_reg <= s_tvalid;
            if (s2_en)
                s2_vld_reg <= s1_vld_reg;
            if (s3_en)
                s3_vld_reg <= s2_vld_reg;
            if (s4_en)
                s4_vld_reg <= s3_vld_reg;
            if (out_en)
                out_vld_reg <= s4_vld_reg;
        end
    end

    // stage 1: saturate u, form 1-u
    logic [UW-1:0] u_in;
    logic [UW-1:0] u_sat;
    logic [UW-1:0] s1_u_reg, s1_v_reg;

    assign u_in  = s_tdata[UW-1:0];
    assign u_sat = (u_in > ONE_FIX) ? ONE_FIX : u_in;

    always_ff @(posedge clk)
    begin
        if (s1_en && s_tvalid)
        begin
            s1_u_reg <= u_sat;
            s1_v_reg <= ONE_FIX - u_sat;
        end
    end

    // stage 2: second degree products
    logic [2*UW-1:0] uu_full, vv_full, uv_full;
    logic [SQ_W-1:0] s2_uu_reg, s2_vv_reg, s2_uv_reg;
    logic [UW-1:0]   s2_u_reg, s2_v_reg;

    assign uu_full = s1_u_reg * s1_u_reg;
    assign vv_full = s1_v_reg * s1_v_reg;
    assign uv_full = s1_u_reg * s1_v_reg;

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_vld_reg)
        begin
            s2_uu_reg <= uu_full[SQ_W-1:0];
            s2_vv_reg <= vv_full[SQ_W-1:0];
            s2_uv_reg <= uv_full[SQ_W-1:0];
            s2_u_reg  <= s1_u_reg;
            s2_v_reg  <= s1_v_reg;
        end
    end

    // stage 3: third degree weights v^3, u v^2, u^2 v, u^3
    logic [SQ_W+UW-1:0] w_full [NUM_CTRL];
    logic [CU_W-1:0]    s3_w_reg [NUM_CTRL];

    assign w_full[0] = s2_vv_reg * s2_v_reg;
    assign w_full[1] = s2_uv_reg * s2_v_reg;
    assign w_full[2] = s2_uv_reg * s2_u_reg;
    assign w_full[3] = s2_uu_reg * s2_u_reg;

    always_ff @(posedge clk)
    begin
        if (s3_en && s2_vld_reg)
        begin
            for (int j = 0; j < NUM_CTRL; j++)
                s3_w_reg[j] <= w_full[j][CU_W-1:0];
        end
    end

    // stage 4: weight times scaled coordinate, floored
    logic [CP_W+CU_W-1:0] tx_full [NUM_CTRL];
    logic [CP_W+CU_W-1:0] ty_full [NUM_CTRL];
    logic [CP_W-1:0]      s4_tx_reg [NUM_CTRL];
    logic [CP_W-1:0]      s4_ty_reg [NUM_CTRL];

    always_comb
    begin
        for (int j = 0; j < NUM_CTRL; j++)
        begin
            tx_full[j] = cx_reg[j] * s3_w_reg[j];
            ty_full[j] = cy_reg[j] * s3_w_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_en && s3_vld_reg)
        begin
            for (int j = 0; j < NUM_CTRL; j++)
            begin
                s4_tx_reg[j] <= tx_full[j][3*FRAC_BITS +: CP_W];
                s4_ty_reg[j] <= ty_full[j][3*FRAC_BITS +: CP_W];
            end
        end
    end

    // stage 5: sum the four terms per axis
    logic [SUM_W-1:0]      sum_x, sum_y;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;

    assign sum_x = SUM_W'(s4_tx_reg[0]) + SUM_W'(s4_tx_reg[1])
                 + SUM_W'(s4_tx_reg[2]) + SUM_W'(s4_tx_reg[3]);
    assign sum_y = SUM_W'(s4_ty_reg[0]) + SUM_W'(s4_ty_reg[1])
                 + SUM_W'(s4_ty_reg[2]) + SUM_W'(s4_ty_reg[3]);

    always_ff @(posedge clk)
    begin
        if (out_en && s4_vld_reg)
        begin
            out_x_reg <= sum_x[COORD_BITS-1:0];
            out_y_reg <= sum_y[COORD_BITS-1:0];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'({out_y_reg, out_x_reg});

    // u and 1-u always add up to one
    logic [UW:0] uv_sum;
    assign uv_sum = (UW+1)'(s1_u_reg) + (UW+1)'(s1_v_reg);

    // bernstein weights including binomials add up to exactly one
    logic [CU_W+2:0] w_sum;
    assign w_sum = (CU_W+3)'(s3_w_reg[0]) + (CU_W+3)'(s3_w_reg[3])
                 + (CU_W+3)'(3) * (CU_W+3)'(s3_w_reg[1])
                 + (CU_W+3)'(3) * (CU_W+3)'(s3_w_reg[2]);

    a_uv_sum: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> uv_sum == (UW+1)'(ONE_FIX))
        else $error("stage 1 u and 1-u do not sum to one");

    a_w_sum: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg |-> w_sum == ((CU_W+3)'(1) << (3*FRAC_BITS)))
        else $error("stage 3 weights do not sum to one");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s1_vld_reg)
        else $error("accepted word did not reach stage 1");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg && !s4_en |=> s4_vld_reg)
        else $error("stalled stage 4 word lost");

endmodule

[tb/sv/bezier_point_checker.sv]
`timescale 1ns / 1ps
// watches the config port and both streams of the cubic bezier point evaluator,
// predicts each curve point and compares it with the output word
// depends on cbpe_pkg

module bezier_point_checker (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                cfg_we,
    input  logic [cbpe_pkg::CFG_IDX_W-1:0]                      cfg_addr,
    input  logic [cbpe_pkg::COORD_BITS_DEF-1:0]                 cfg_data,
    input  logic                                                s_tvalid,
    input  logic                                                s_tready,
    input  logic [((cbpe_pkg::FRAC_BITS_DEF+8)/8)*8-1:0]        s_tdata,    // u_param
    input  logic                                                m_tvalid,
    input  logic                                                m_tready,
    input  logic [((2*cbpe_pkg::COORD_BITS_DEF+7)/8)*8-1:0]     m_tdata,    // point_x, point_y
    output int                                                  mismatches,
    output int                                                  outstanding
);

    import cbpe_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam logic [63:0] UNIT = 64'd1 << FB;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } point_t;

    point_t        point_fifo [$];
    logic [CB-1:0] ctrl_reg [2*NUM_CTRL];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // exact bernstein weights scaled by 2^(3*FB); every product fits 64 bits
    function automatic point_t eval_point(input logic [FB:0] u_raw);
        logic [63:0] uu;
        logic [63:0] vv;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] wt [NUM_CTRL];
        point_t      pt;
        uu = (64'(u_raw) > UNIT) ? UNIT : 64'(u_raw);
        vv = UNIT - uu;
        wt[0] = vv * vv * vv;
        wt[1] = 64'd3 * uu * vv * vv;
        wt[2] = 64'd3 * uu * uu * vv;
        wt[3] = uu * uu * uu;
        sx = '0;
        sy = '0;
        for (int j = 0; j < NUM_CTRL; j++)
        begin
            sx += (64'(ctrl_reg[2*j]) * wt[j]) >> (3*FB);
            sy += (64'(ctrl_reg[2*j+1]) * wt[j]) >> (3*FB);
        end
        pt.x = sx[CB-1:0];
        pt.y = sy[CB-1:0];
        return pt;
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            foreach (ctrl_reg[i])
                ctrl_reg[i] = '0;
            point_fifo.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (point_fifo.size() == 0)
                    report_mismatch("unexpected point word", int'(m_tdata[2*CB-1:0]), 0);
                else
                begin
                    want = point_fifo.pop_front();
                    if (m_tdata[CB-1:0] !== want.x)
                        report_mismatch("point_x", int'(m_tdata[CB-1:0]), int'(want.x));
                    if (m_tdata[2*CB-1:CB] !== want.y)
                        report_mismatch("point_y", int'(m_tdata[2*CB-1:CB]), int'(want.y));
                end
            end
            if (s_tvalid && s_tready)
                point_fifo.push_back(eval_point(s_tdata[FB:0]));
            if (cfg_we)
                ctrl_reg[cfg_addr] = cfg_data;
        end
        outstanding = point_fifo.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// stimulus and verdict for cubic_bezier_point_eval_unit: control point settings,
// curve parameter words and random stalls; checking lives in bezier_point_checker
// depends on cbpe_pkg, cubic_bezier_point_eval_unit and bezier_point_checker

module tb_top;
    import cbpe_pkg::*;

    localparam int CB     = COORD_BITS_DEF;
    localparam int FB     = FRAC_BITS_DEF;
    localparam int IN_W   = ((FB+8)/8)*8;
    localparam int OUT_W  = ((2*CB+7)/8)*8;
    localparam int U_ONE  = 1 << FB;
    localparam int U_MAX  = (1 << (FB+1)) - 1;
    localparam int C_MAX  = (1 << CB) - 1;
    localparam int PIPE_SETTLE = 8;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CB-1:0]     cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;    // u_param
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;    // point_x, point_y

    int mismatches;
    int outstanding;
    bit idle_on;
    bit hold_req;
    bit hold_taken;
    int hold_left;

    cubic_bezier_point_eval_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bezier_point_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // output side: random stalls plus one long hold on request
    initial
    begin
        m_tready   = 1'b0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_left  = 64;
                hold_taken = 1'b1;
            end
            if (!rst_n)
                m_tready = 1'b0;
            else if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = !(idle_on && $urandom_range(99) < 9);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_u(input logic [FB:0] u);
        while (idle_on && $urandom_range(99) < 9)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = '0;
        s_tdata[FB:0] = u;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drain the pipe, then rewrite all eight coordinates
    task automatic load_points(input logic [CB-1:0] pts [2*NUM_CTRL]);
        cfg_reg_t idx;
        s_tvalid = 1'b0;
        wait (outstanding == 0);
        repeat (PIPE_SETTLE) @(posedge clk);
        @(negedge clk);
        idx = REG_X0;
        for (int i = 0; i < idx.num(); i++)
        begin
            cfg_we   = 1'b1;
            cfg_addr = idx;
            cfg_data = pts[i];
            @(negedge clk);
            idx = idx.next();
        end
        cfg_we = 1'b0;
    endtask

    function automatic logic [CB-1:0] pick_coord();
        case ($urandom_range(9))
            0: return '0;
            1: return C_MAX[CB-1:0];
            default: return CB'($urandom_range(C_MAX));
        endcase
    endfunction

    function automatic logic [FB:0] pick_u();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return '0;
        else if (r < 6)
            return U_ONE[FB:0];
        else if (r < 8)
            return (FB+1)'(U_ONE - 1);
        else if (r < 20)
            return (FB+1)'($urandom_range(U_MAX, U_ONE + 1));   // saturates to 1.0
        else
            return (FB+1)'($urandom_range(U_ONE));
    endfunction

    logic [CB-1:0] pts [2*NUM_CTRL];
    logic [FB:0]   all_max_u [9];
    logic [FB:0]   zigzag_u [7];

    initial
    begin
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = REG_X0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        idle_on  = 1'b0;
        hold_req = 1'b0;
        all_max_u = '{(FB+1)'(0), (FB+1)'(1), (FB+1)'(2), (FB+1)'(U_ONE/2),
                      (FB+1)'(U_ONE-1), (FB+1)'(U_ONE), (FB+1)'(U_ONE+1),
                      (FB+1)'(U_ONE+U_ONE/2), (FB+1)'(U_MAX)};
        zigzag_u  = '{(FB+1)'(0), (FB+1)'(U_ONE/3), (FB+1)'((2*U_ONE+2)/3),
                      (FB+1)'(U_ONE), (FB+1)'(U_MAX), 17'h0AAAA, 17'h15555};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values: every point is the origin
        send_u('0);
        send_u(U_ONE[FB:0]);

        // all coordinates at the top of the range
        foreach (pts[i])
            pts[i] = C_MAX[CB-1:0];
        load_points(pts);
        foreach (all_max_u[i])
            send_u(all_max_u[i]);

        // alternating extremes between the axes
        foreach (pts[i])
            pts[i] = (i % 4 == 0 || i % 4 == 3) ? C_MAX[CB-1:0] : '0;
        load_points(pts);
        foreach (zigzag_u[i])
            send_u(zigzag_u[i]);

        for (int phase = 0; phase < 6; phase++)
        begin
            foreach (pts[i])
                pts[i] = pick_coord();
            load_points(pts);
            idle_on = (phase != 0);
            for (int n = 0; n < 90; n++)
            begin
                if (phase == 2 && n == 20)
                    hold_req = 1'b1;
                if (phase == 3 && n == 45)
                begin
                    s_tvalid = 1'b0;
                    wait (outstanding == 0);
                    @(negedge clk);
                end
                send_u(pick_u());
            end
        end

        s_tvalid = 1'b0;
        wait (outstanding == 0);
        repeat (PIPE_SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
